@@ sv/tspls_pkg.sv @@
// ----------------------------------------------------------------------------
// tspls_pkg: shared types and codes of the TSP local search move engine
// Request and response words, request and move codes, status codes, sequencer states.
// ----------------------------------------------------------------------------
package tspls_pkg;

    localparam int MAX_CITIES_DEF = 256;
    localparam int DIST_BITS_DEF  = 24;

    localparam int CITY_W   = 9;
    localparam int DIST_W   = 24;
    localparam int DELTA_W  = 27;
    localparam int COST_W   = 32;
    localparam int STATUS_W = 2;
    localparam int REQ_W    = 3;
    localparam int KIND_W   = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_APPLY = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_SWAP    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TWO_OPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OR2     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OR3     = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

    localparam logic signed [63:0] DELTA_MAX = 64'sd67108863;
    localparam logic signed [63:0] DELTA_MIN = -64'sd67108864;
    localparam logic signed [63:0] COST_MAX  = 64'sd4294967295;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [KIND_W-1:0] move_kind;
        logic [CITY_W-1:0] first_pos;
        logic [CITY_W-1:0] second_pos;
        logic [CITY_W-1:0] from_city;
        logic [CITY_W-1:0] to_city;
        logic [DIST_W-1:0] distance_value;
    } req_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] cost_delta;
        logic [COST_W-1:0]         tour_cost;
        logic [CITY_W-1:0]         city_at_pos;
        logic [STATUS_W-1:0]       status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BUILD,
        ST_BUILD_END,
        ST_READ,
        ST_ARC,
        ST_ARC_END,
        ST_SWAP_RD,
        ST_SWAP_W1,
        ST_SWAP_W2,
        ST_OR_RD1,
        ST_OR_RD2,
        ST_OR_SHIFT,
        ST_OR_PUT,
        ST_FIN
    } state_t;

endpackage

@@ sv/tsp_local_search_move_engine_core.sv @@
// ----------------------------------------------------------------------------
// tsp_local_search_move_engine_core: TSP tour move engine
// Distance matrix and closed tour in on-chip memories; loads entries, builds
// the identity tour, reads positions, evaluates and applies swap, 2-opt and
// or-opt moves with their signed integer cost delta.
// ----------------------------------------------------------------------------
//  channel | signals                      | direction | word
//  req     | req_valid, req_stall, req    | in        | tspls_pkg::req_t
//  rsp     | rsp_valid, rsp_stall, rsp    | out       | tspls_pkg::rsp_t
//  cfg     | cfg_write, cfg_data          | in        | city_count, 9 bits
//
//  One word at a time. Evaluate: one tour-pair read per cycle for the 4, 6
//  or 8 arcs, each followed by a matrix read. Apply adds the tour rewrite:
//  swap reads both positions and writes each back, 2-opt does so per
//  swapped pair, or-opt shifts the cities after the block of k, up to j,
//  left and puts the block at j. Build: one tour write, one matrix read per cycle.
//  Reset clears the sequencer, the running cost and sets city_count to 3;
//  the memories are not cleared. A stalled response holds in its register
//  while the next request is already taken and worked on.
// ----------------------------------------------------------------------------
module tsp_local_search_move_engine_core #(
    parameter int MAX_CITIES = tspls_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = tspls_pkg::DIST_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  tspls_pkg::req_t                 req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output tspls_pkg::rsp_t                 rsp,
    input  logic                            cfg_write,
    input  logic [tspls_pkg::CITY_W-1:0]    cfg_data
);
    import tspls_pkg::*;

    localparam int TIDX_W = $clog2(MAX_CITIES + 1);
    localparam int DA_W   = $clog2(MAX_CITIES * MAX_CITIES);
    localparam int ACC_W  = DIST_BITS + $clog2(MAX_CITIES) + 3;

    // storage: tour with two read ports, matrix with one
    logic [CITY_W-1:0]    tour_mem [MAX_CITIES+1];
    logic [DIST_BITS-1:0] dist_mem [MAX_CITIES*MAX_CITIES];

    logic              t_we, t_re_a, t_re_b;
    logic [TIDX_W-1:0] t_waddr, t_ra, t_rb;
    logic [CITY_W-1:0] t_wdata, t_qa, t_qb;
    logic                 d_we, d_re;
    logic [DA_W-1:0]      d_waddr, d_raddr;
    logic [DIST_BITS-1:0] d_wdata, d_q;

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tour_mem[t_waddr] <= t_wdata;
        end
        if (t_re_a)
        begin
            t_qa <= tour_mem[t_ra];
        end
        if (t_re_b)
        begin
            t_qb <= tour_mem[t_rb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            dist_mem[d_waddr] <= d_wdata;
        end
        if (d_re)
        begin
            d_q <= dist_mem[d_raddr];
        end
    end

    function automatic logic [DA_W-1:0] dist_addr(input logic [CITY_W-1:0] a,
                                                  input logic [CITY_W-1:0] b);
        return DA_W'((int'(a) - 1) * MAX_CITIES + (int'(b) - 1));
    endfunction

    function automatic logic city_ok(input logic [CITY_W-1:0] c);
        return (c != '0) && (int'(c) <= MAX_CITIES);
    endfunction

    // registers
    state_t                    state_reg, state_next;
    req_t                      req_reg;
    logic [CITY_W-1:0]         n_reg;
    logic [TIDX_W-1:0]         ptr_a_reg, ptr_a_next, ptr_b_reg, ptr_b_next;
    logic [2:0]                cnt_reg, cnt_next;
    logic                      v1_reg, v1_next, v2_reg, v2_next;
    logic                      neg1_reg, neg1_next, neg2_reg, neg2_next;
    logic                      ok2_reg, ok2_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [CITY_W-1:0]         blk0_reg, blk0_next, blk1_reg, blk1_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic [CITY_W-1:0]         city_reg, city_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [COST_W-1:0]         cost_reg, cost_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    // decoded request
    logic [CITY_W-1:0]  i9, j9;
    logic [KIND_W-1:0]  kind;
    logic [TIDX_W-1:0]  i_t, j_t, k_t;
    logic               adj, n_ok, move_ok;

    assign i9   = req_reg.first_pos;
    assign j9   = req_reg.second_pos;
    assign kind = req_reg.move_kind;
    assign i_t  = TIDX_W'(i9);
    assign j_t  = TIDX_W'(j9);
    assign k_t  = (kind == KIND_OR2) ? TIDX_W'(2) : TIDX_W'(3);
    assign adj  = ({1'b0, j9} == {1'b0, i9} + 10'd1);
    assign n_ok = (n_reg >= 9'd3) && (int'(n_reg) <= MAX_CITIES);

    always_comb
    begin
        move_ok = (j9 < n_reg) && (j9 > i9);
        unique case (kind)
            KIND_SWAP:    move_ok = move_ok && (i9 != '0);
            KIND_TWO_OPT: move_ok = move_ok;
            default:      move_ok = move_ok && (i9 != '0) &&
                                    ({1'b0, j9} >= {1'b0, i9} + ((kind == KIND_OR2)
                                                                  ? 10'd2 : 10'd3));
        endcase
    end

    // arc table: positions of each tour arc of the move, and its sign
    logic [TIDX_W-1:0] im1, ip1, jm1, jp1, ik, ikm1;
    logic [TIDX_W-1:0] arc_p, arc_q;
    logic              arc_neg;
    logic [2:0]        arc_last;

    assign im1  = i_t - TIDX_W'(1);
    assign ip1  = i_t + TIDX_W'(1);
    assign jm1  = j_t - TIDX_W'(1);
    assign jp1  = j_t + TIDX_W'(1);
    assign ik   = i_t + k_t;
    assign ikm1 = ik - TIDX_W'(1);

    always_comb
    begin
        arc_p    = i_t;
        arc_q    = j_t;
        arc_neg  = 1'b0;
        arc_last = 3'd3;
        unique case (kind)
            KIND_SWAP:
            begin
                if (adj)
                begin
                    arc_last = 3'd3;
                    unique case (cnt_reg[1:0])
                        2'd0:    begin arc_p = im1; arc_q = j_t; end
                        2'd1:    begin arc_p = i_t; arc_q = jp1; end
                        2'd2:    begin arc_p = im1; arc_q = i_t; arc_neg = 1'b1; end
                        default: begin arc_p = j_t; arc_q = jp1; arc_neg = 1'b1; end
                    endcase
                end
                else
                begin
                    arc_last = 3'd7;
                    unique case (cnt_reg)
                        3'd0:    begin arc_p = im1; arc_q = j_t; end
                        3'd1:    begin arc_p = j_t; arc_q = ip1; end
                        3'd2:    begin arc_p = jm1; arc_q = i_t; end
                        3'd3:    begin arc_p = i_t; arc_q = jp1; end
                        3'd4:    begin arc_p = im1; arc_q = i_t; arc_neg = 1'b1; end
                        3'd5:    begin arc_p = i_t; arc_q = ip1; arc_neg = 1'b1; end
                        3'd6:    begin arc_p = jm1; arc_q = j_t; arc_neg = 1'b1; end
                        default: begin arc_p = j_t; arc_q = jp1; arc_neg = 1'b1; end
                    endcase
                end
            end
            KIND_TWO_OPT:
            begin
                arc_last = 3'd3;
                unique case (cnt_reg[1:0])
                    2'd0:    begin arc_p = i_t; arc_q = j_t; end
                    2'd1:    begin arc_p = ip1; arc_q = jp1; end
                    2'd2:    begin arc_p = i_t; arc_q = ip1; arc_neg = 1'b1; end
                    default: begin arc_p = j_t; arc_q = jp1; arc_neg = 1'b1; end
                endcase
            end
            default:
            begin
                arc_last = 3'd5;
                unique case (cnt_reg)
                    3'd0:    begin arc_p = im1;  arc_q = ik;  end
                    3'd1:    begin arc_p = j_t;  arc_q = i_t; end
                    3'd2:    begin arc_p = ikm1; arc_q = jp1; end
                    3'd3:    begin arc_p = im1;  arc_q = i_t; arc_neg = 1'b1; end
                    3'd4:    begin arc_p = ikm1; arc_q = ik;  arc_neg = 1'b1; end
                    default: begin arc_p = j_t;  arc_q = jp1; arc_neg = 1'b1; end
                endcase
            end
        endcase
    end

    // accumulate stage: add or subtract the returned distance
    logic signed [ACC_W-1:0] d_ext, term;
    logic signed [63:0]      acc_wide, cost_sum;
    logic [CITY_W-1:0]       build_a, build_b;

    assign d_ext    = $signed({{(ACC_W-DIST_BITS){1'b0}}, d_q});
    assign term     = ok2_reg ? (neg2_reg ? -d_ext : d_ext) : '0;
    assign acc_wide = 64'(acc_reg);
    assign cost_sum = $signed({32'd0, cost_reg}) + acc_wide;
    assign build_a  = CITY_W'(ptr_a_reg + TIDX_W'(1));
    assign build_b  = (ptr_a_reg + TIDX_W'(1) < TIDX_W'(n_reg))
                      ? CITY_W'(ptr_a_reg + TIDX_W'(2)) : CITY_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        ptr_a_next     = ptr_a_reg;
        ptr_b_next     = ptr_b_reg;
        cnt_next       = cnt_reg;
        v1_next        = 1'b0;
        v2_next        = 1'b0;
        neg1_next      = neg1_reg;
        neg2_next      = neg2_reg;
        ok2_next       = ok2_reg;
        acc_next       = v2_reg ? acc_reg + term : acc_reg;
        blk0_next      = blk0_reg;
        blk1_next      = blk1_reg;
        delta_next     = delta_reg;
        city_next      = city_reg;
        status_next    = status_reg;
        cost_next      = cost_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        t_we    = 1'b0;
        t_waddr = ptr_a_reg;
        t_wdata = t_qb;
        t_re_a  = 1'b0;
        t_ra    = i_t;
        t_re_b  = 1'b0;
        t_rb    = j_t;
        d_we    = 1'b0;
        d_waddr = dist_addr(req_reg.from_city, req_reg.to_city);
        d_wdata = DIST_BITS'(req_reg.distance_value);
        d_re    = 1'b0;
        d_raddr = dist_addr(t_qa, t_qb);

        // matrix read for the tour pair returned last cycle
        if (v1_reg)
        begin
            d_re      = 1'b1;
            v2_next   = 1'b1;
            neg2_next = neg1_reg;
            ok2_next  = city_ok(t_qa) && city_ok(t_qb);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                delta_next  = '0;
                city_next   = '0;
                status_next = STATUS_OK;
                acc_next    = '0;
                cnt_next    = '0;
                ptr_a_next  = '0;
                state_next  = ST_FIN;
                if (req_reg.req_type == REQ_LOAD)
                begin
                    if (city_ok(req_reg.from_city) && city_ok(req_reg.to_city))
                    begin
                        d_we = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_RANGE;
                    end
                end
                else if (req_reg.req_type > REQ_READ || !n_ok)
                begin
                    status_next = STATUS_RANGE;
                end
                else if (req_reg.req_type == REQ_BUILD)
                begin
                    state_next = ST_BUILD;
                end
                else if (req_reg.req_type == REQ_READ)
                begin
                    if (i9 > n_reg)
                    begin
                        status_next = STATUS_RANGE;
                    end
                    else
                    begin
                        t_re_a     = 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (!move_ok)
                begin
                    status_next = STATUS_RANGE;
                end
                else
                begin
                    state_next = ST_ARC;
                end
            end
            ST_BUILD:
            begin
                // write one identity entry and fetch its arc, then close the tour
                t_we    = 1'b1;
                t_waddr = ptr_a_reg;
                if (ptr_a_reg < TIDX_W'(n_reg))
                begin
                    t_wdata   = build_a;
                    d_re      = 1'b1;
                    d_raddr   = dist_addr(build_a, build_b);
                    v2_next   = 1'b1;
                    neg2_next = 1'b0;
                    ok2_next  = 1'b1;
                    ptr_a_next = ptr_a_reg + TIDX_W'(1);
                end
                else
                begin
                    t_wdata    = CITY_W'(1);
                    state_next = ST_BUILD_END;
                end
            end
            ST_BUILD_END:
            begin
                if (acc_wide > COST_MAX)
                begin
                    cost_next   = '1;
                    status_next = STATUS_SAT;
                end
                else
                begin
                    cost_next = COST_W'(acc_reg);
                end
                state_next = ST_FIN;
            end
            ST_READ:
            begin
                city_next  = t_qa;
                state_next = ST_FIN;
            end
            ST_ARC:
            begin
                // issue one tour pair a cycle
                t_re_a    = 1'b1;
                t_ra      = arc_p;
                t_re_b    = 1'b1;
                t_rb      = arc_q;
                v1_next   = 1'b1;
                neg1_next = arc_neg;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == arc_last)
                begin
                    state_next = ST_ARC_END;
                end
            end
            ST_ARC_END:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_FIN;
                    if (acc_wide > DELTA_MAX)
                    begin
                        delta_next  = DELTA_W'(DELTA_MAX);
                        status_next = STATUS_SAT;
                    end
                    else if (acc_wide < DELTA_MIN)
                    begin
                        delta_next  = DELTA_W'(DELTA_MIN);
                        status_next = STATUS_SAT;
                    end
                    else
                    begin
                        delta_next = DELTA_W'(acc_reg);
                    end
                    if (req_reg.req_type == REQ_APPLY)
                    begin
                        if (cost_sum < 64'sd0)
                        begin
                            cost_next   = '0;
                            status_next = STATUS_SAT;
                        end
                        else if (cost_sum > COST_MAX)
                        begin
                            cost_next   = '1;
                            status_next = STATUS_SAT;
                        end
                        else
                        begin
                            cost_next = COST_W'(cost_sum);
                        end
                        cnt_next = '0;
                        unique case (kind)
                            KIND_SWAP:
                            begin
                                ptr_a_next = i_t;
                                ptr_b_next = j_t;
                                state_next = ST_SWAP_RD;
                            end
                            KIND_TWO_OPT:
                            begin
                                ptr_a_next = ip1;
                                ptr_b_next = j_t;
                                if (ip1 < j_t)
                                begin
                                    state_next = ST_SWAP_RD;
                                end
                            end
                            default:
                            begin
                                state_next = ST_OR_RD1;
                            end
                        endcase
                    end
                end
            end
            ST_SWAP_RD:
            begin
                t_re_a     = 1'b1;
                t_ra       = ptr_a_reg;
                t_re_b     = 1'b1;
                t_rb       = ptr_b_reg;
                state_next = ST_SWAP_W1;
            end
            ST_SWAP_W1:
            begin
                t_we       = 1'b1;
                t_waddr    = ptr_a_reg;
                t_wdata    = t_qb;
                state_next = ST_SWAP_W2;
            end
            ST_SWAP_W2:
            begin
                t_we       = 1'b1;
                t_waddr    = ptr_b_reg;
                t_wdata    = t_qa;
                ptr_a_next = ptr_a_reg + TIDX_W'(1);
                ptr_b_next = ptr_b_reg - TIDX_W'(1);
                // for 2-opt, advance the reversal inward until the pointers meet
                if (kind == KIND_TWO_OPT && ptr_a_reg + TIDX_W'(1) < ptr_b_reg - TIDX_W'(1))
                begin
                    state_next = ST_SWAP_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_OR_RD1:
            begin
                t_re_a     = 1'b1;
                t_ra       = i_t;
                t_re_b     = 1'b1;
                t_rb       = ip1;
                state_next = ST_OR_RD2;
            end
            ST_OR_RD2:
            begin
                // third block city stays held on port a through the shift
                blk0_next  = t_qa;
                blk1_next  = t_qb;
                t_re_a     = 1'b1;
                t_ra       = i_t + TIDX_W'(2);
                t_re_b     = 1'b1;
                t_rb       = ik;
                ptr_a_next = i_t;
                state_next = ST_OR_SHIFT;
            end
            ST_OR_SHIFT:
            begin
                t_we    = 1'b1;
                t_waddr = ptr_a_reg;
                t_wdata = t_qb;
                if (ptr_a_reg == j_t - k_t)
                begin
                    state_next = ST_OR_PUT;
                end
                else
                begin
                    t_re_b     = 1'b1;
                    t_rb       = ptr_a_reg + TIDX_W'(1) + k_t;
                    ptr_a_next = ptr_a_reg + TIDX_W'(1);
                end
            end
            ST_OR_PUT:
            begin
                t_we    = 1'b1;
                t_waddr = jp1 - k_t + TIDX_W'(cnt_reg);
                unique case (cnt_reg)
                    3'd0:    t_wdata = blk0_reg;
                    3'd1:    t_wdata = blk1_reg;
                    default: t_wdata = t_qa;
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (TIDX_W'(cnt_reg) == k_t - TIDX_W'(1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold the result until the response register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.cost_delta  = delta_reg;
                    rsp_next.tour_cost   = cost_reg;
                    rsp_next.city_at_pos = city_reg;
                    rsp_next.status      = status_reg;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= CITY_W'(3);
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            cost_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            cost_reg      <= cost_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
            begin
                n_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        ptr_a_reg  <= ptr_a_next;
        ptr_b_reg  <= ptr_b_next;
        cnt_reg    <= cnt_next;
        neg1_reg   <= neg1_next;
        neg2_reg   <= neg2_next;
        ok2_reg    <= ok2_next;
        acc_reg    <= acc_next;
        blk0_reg   <= blk0_next;
        blk1_reg   <= blk1_next;
        delta_reg  <= delta_next;
        city_reg   <= city_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    // a rejected request never reports a delta
    a_range_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_RANGE |-> rsp.cost_delta == '0)
        else $error("range error with nonzero delta");

    // an accepted word always starts decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == ST_DECODE)
        else $error("accepted word not decoded");

    // the arc pipeline drains before the move result is formed
    a_arc_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> !v1_reg && !v2_reg)
        else $error("arc pipeline busy at finish");

endmodule

@@ dv/tb_tsp_local_search_move_engine_core.sv @@
// ----------------------------------------------------------------------------
// tb_tsp_local_search_move_engine_core: self-checking bench of the move engine
// Drives request words from a queue, predicts every response with a local
// model of the matrix, tour and running cost, and checks each response word.
// ----------------------------------------------------------------------------
module tb_tsp_local_search_move_engine_core;
    import tspls_pkg::*;

    localparam int NCITY = 256;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    req_t                req = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    rsp_t                rsp;
    logic                cfg_write = 1'b0;
    logic [CITY_W-1:0]   cfg_data = '0;

    tsp_local_search_move_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Request words waiting for the driver, and response words they will cause.
    req_t pending_requests[$];
    rsp_t expected_responses[$];

    // Local copy of the engine state.
    logic [DIST_W-1:0] dist_mem [0:NCITY*NCITY-1];
    bit                dist_loaded [0:NCITY*NCITY-1];
    int                tour_city [0:NCITY];
    int                tour_extent = -1;   // positions 0..tour_extent were written
    longint            cost_now = 0;
    int                city_count = 3;

    int     mismatches = 0;
    longint cycles = 0;
    bit     send_burst = 1'b0;
    bit     take_burst = 1'b0;
    int     send_gap = 0;
    int     hold_left = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic int pause_len(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic longint dist_of(input int a, input int b);
        if (a < 1 || a > NCITY || b < 1 || b > NCITY)
            return 0;
        return longint'(dist_mem[(a-1)*NCITY + (b-1)]);
    endfunction

    function automatic longint arc_of(input int p, input int q);
        return dist_of(tour_city[p], tour_city[q]);
    endfunction

    function automatic bit move_legal(input int kind, input int i, input int j);
        if (city_count < 3 || city_count > NCITY)
            return 0;
        if (j >= city_count || j <= i)
            return 0;
        if (kind == KIND_SWAP)
            return i >= 1;
        if (kind == KIND_TWO_OPT)
            return 1;
        return i >= 1 && j >= i + kind;
    endfunction

    function automatic longint move_delta(input int kind, input int i, input int j);
        int k;
        if (kind == KIND_SWAP) begin
            if (j == i + 1)
                return arc_of(i-1, j) + arc_of(i, j+1) - arc_of(i-1, i) - arc_of(j, j+1);
            return arc_of(i-1, j) + arc_of(j, i+1) + arc_of(j-1, i) + arc_of(i, j+1)
                 - arc_of(i-1, i) - arc_of(i, i+1) - arc_of(j-1, j) - arc_of(j, j+1);
        end
        if (kind == KIND_TWO_OPT)
            return arc_of(i, j) + arc_of(i+1, j+1) - arc_of(i, i+1) - arc_of(j, j+1);
        k = kind;
        return arc_of(i-1, i+k) + arc_of(j, i) + arc_of(i+k-1, j+1)
             - arc_of(i-1, i) - arc_of(i+k-1, i+k) - arc_of(j, j+1);
    endfunction

    function automatic void rewrite_tour(input int kind, input int i, input int j);
        int t, a, b, k;
        int blk [0:2];
        if (kind == KIND_SWAP) begin
            t = tour_city[i];
            tour_city[i] = tour_city[j];
            tour_city[j] = t;
        end else if (kind == KIND_TWO_OPT) begin
            a = i + 1;
            b = j;
            while (a < b) begin
                t = tour_city[a];
                tour_city[a] = tour_city[b];
                tour_city[b] = t;
                a++;
                b--;
            end
        end else begin
            // Lift the block, shift the cities between left, drop it after j.
            k = kind;
            for (int m = 0; m < k; m++)
                blk[m] = tour_city[i+m];
            for (int p = i; p <= j - k; p++)
                tour_city[p] = tour_city[p+k];
            for (int m = 0; m < k; m++)
                tour_city[j+1-k+m] = blk[m];
        end
    endfunction

    function automatic rsp_t engine_step(input req_t r);
        rsp_t   o;
        int     i, j, fc, tc, kind, n;
        longint d, c;
        o    = '0;
        i    = r.first_pos;
        j    = r.second_pos;
        fc   = r.from_city;
        tc   = r.to_city;
        kind = r.move_kind;
        n    = city_count;
        if (r.req_type == REQ_LOAD) begin
            if (fc < 1 || fc > NCITY || tc < 1 || tc > NCITY) begin
                o.status = STATUS_RANGE;
            end else begin
                dist_mem[(fc-1)*NCITY + (tc-1)]    = r.distance_value;
                dist_loaded[(fc-1)*NCITY + (tc-1)] = 1'b1;
            end
        end else if (r.req_type > REQ_READ || n < 3 || n > NCITY) begin
            o.status = STATUS_RANGE;
        end else if (r.req_type == REQ_BUILD) begin
            c = 0;
            for (int p = 0; p < n; p++)
                tour_city[p] = p + 1;
            tour_city[n] = 1;
            for (int p = 0; p < n; p++)
                c += arc_of(p, p+1);
            if (c > COST_MAX) begin
                c = COST_MAX;
                o.status = STATUS_SAT;
            end
            cost_now = c;
            if (n > tour_extent)
                tour_extent = n;
        end else if (r.req_type == REQ_READ) begin
            if (i > n)
                o.status = STATUS_RANGE;
            else
                o.city_at_pos = CITY_W'(tour_city[i]);
        end else if (!move_legal(kind, i, j)) begin
            o.status = STATUS_RANGE;
        end else begin
            d = move_delta(kind, i, j);
            if (d > DELTA_MAX) begin
                o.cost_delta = DELTA_W'(DELTA_MAX);
                o.status = STATUS_SAT;
            end else if (d < DELTA_MIN) begin
                o.cost_delta = DELTA_W'(DELTA_MIN);
                o.status = STATUS_SAT;
            end else begin
                o.cost_delta = DELTA_W'(d);
            end
            if (r.req_type == REQ_APPLY) begin
                // Cost takes the exact delta, not the clamped one.
                c = cost_now + d;
                if (c < 0) begin
                    c = 0;
                    o.status = STATUS_SAT;
                end else if (c > COST_MAX) begin
                    c = COST_MAX;
                    o.status = STATUS_SAT;
                end
                cost_now = c;
                rewrite_tour(kind, i, j);
            end
        end
        o.tour_cost = cost_now[31:0];
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers: every request is predicted as it is queued
    // ------------------------------------------------------------------------
    function automatic logic [DIST_W-1:0] pick_distance();
        int s;
        s = $urandom_range(0, 9);
        if (s < 3)
            return '1;
        if (s == 3)
            return '0;
        if (s < 7)
            return DIST_W'($urandom_range(0, 2047));
        return DIST_W'($urandom);
    endfunction

    // Unused fields carry random noise.
    function automatic req_t make_req(input logic [REQ_W-1:0] kind_of_req);
        req_t r;
        r = '0;
        r.req_type       = kind_of_req;
        r.move_kind      = KIND_W'($urandom);
        r.first_pos      = CITY_W'($urandom);
        r.second_pos     = CITY_W'($urandom);
        r.from_city      = CITY_W'($urandom);
        r.to_city        = CITY_W'($urandom);
        r.distance_value = DIST_W'($urandom);
        return r;
    endfunction

    task automatic send(input req_t r);
        expected_responses.push_back(engine_step(r));
        pending_requests.push_back(r);
    endtask

    task automatic do_load(input int fc, input int tc, input logic [DIST_W-1:0] dv);
        req_t r;
        r = make_req(REQ_LOAD);
        r.from_city      = CITY_W'(fc);
        r.to_city        = CITY_W'(tc);
        r.distance_value = dv;
        send(r);
    endtask

    // Load a matrix entry before anything reads it.
    task automatic need_pair(input int a, input int b);
        if (a >= 1 && a <= NCITY && b >= 1 && b <= NCITY && !dist_loaded[(a-1)*NCITY + (b-1)])
            do_load(a, b, pick_distance());
    endtask

    task automatic need_arc(input int p, input int q);
        need_pair(tour_city[p], tour_city[q]);
    endtask

    task automatic do_build();
        if (city_count >= 3 && city_count <= NCITY) begin
            for (int c = 1; c < city_count; c++)
                need_pair(c, c + 1);
            need_pair(city_count, 1);
        end
        send(make_req(REQ_BUILD));
    endtask

    task automatic do_read(input int pos);
        req_t r;
        if (city_count >= 3 && city_count <= NCITY && pos <= city_count && pos > tour_extent)
            do_build();
        r = make_req(REQ_READ);
        r.first_pos = CITY_W'(pos);
        send(r);
    endtask

    task automatic do_move(input logic [REQ_W-1:0] rq, input int kind, input int i, input int j);
        req_t r;
        int   k;
        if (move_legal(kind, i, j)) begin
            if (city_count > tour_extent)
                do_build();
            if (kind == KIND_SWAP) begin
                need_arc(i-1, j); need_arc(i, j+1); need_arc(i-1, i); need_arc(j, j+1);
                need_arc(j, i+1); need_arc(j-1, i); need_arc(i, i+1); need_arc(j-1, j);
            end else if (kind == KIND_TWO_OPT) begin
                need_arc(i, j); need_arc(i+1, j+1); need_arc(i, i+1); need_arc(j, j+1);
            end else begin
                k = kind;
                need_arc(i-1, i+k); need_arc(j, i); need_arc(i+k-1, j+1);
                need_arc(i-1, i); need_arc(i+k-1, i+k); need_arc(j, j+1);
            end
        end
        r = make_req(rq);
        r.move_kind  = KIND_W'(kind);
        r.first_pos  = CITY_W'(i);
        r.second_pos = CITY_W'(j);
        send(r);
    endtask

    // A move whose positions fit the kind, when the count leaves room for one.
    task automatic random_move();
        int kind, i, j, n;
        logic [REQ_W-1:0] rq;
        n    = city_count;
        kind = $urandom_range(0, 3);
        rq   = $urandom_range(0, 1) ? REQ_APPLY : REQ_EVAL;
        if (kind == KIND_SWAP && n >= 3) begin
            i = $urandom_range(1, n - 2);
            j = ($urandom_range(0, 2) == 0) ? i + 1 : $urandom_range(i + 1, n - 1);
        end else if (kind == KIND_TWO_OPT) begin
            i = $urandom_range(0, n - 2);
            j = $urandom_range(i + 1, n - 1);
        end else if (n - 1 - kind >= 1) begin
            i = $urandom_range(1, n - 1 - kind);
            j = $urandom_range(i + kind, n - 1);
        end else begin
            i = $urandom_range(0, n);
            j = $urandom_range(0, n);
        end
        do_move(rq, kind, i, j);
    endtask

    task automatic random_item();
        int s, n, hi;
        s  = $urandom_range(0, 99);
        n  = city_count;
        hi = (n > NCITY) ? NCITY : n;
        if (s < 10) begin
            if ($urandom_range(0, 19) == 0)
                do_load($urandom_range(0, 1) ? 0 : $urandom_range(NCITY + 1, 511),
                        $urandom_range(0, 511), DIST_W'($urandom));
            else
                do_load($urandom_range(1, hi), $urandom_range(1, hi), pick_distance());
        end else if (s < 13) begin
            do_build();
        end else if (s < 25) begin
            do_read($urandom_range(0, n + ($urandom_range(0, 7) == 0)));
        end else if (s < 29) begin
            send(make_req(REQ_W'($urandom_range(5, 7))));
        end else if (s < 35) begin
            // broken move: random positions, most of them out of range
            do_move($urandom_range(0, 1) ? REQ_APPLY : REQ_EVAL, $urandom_range(0, 3),
                    $urandom_range(0, 511), $urandom_range(0, 511));
        end else begin
            random_move();
        end
    endtask

    // Hold until every queued word is answered.
    task automatic drain();
        while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_count(input int v);
        drain();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= CITY_W'(v);
        @(posedge clk);
        cfg_write <= 1'b0;
        city_count = v;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the next word after the drawn gap, hold while stalled
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            send_gap  = 0;
        end else if (req_valid && req_stall) begin
            // hold the word
        end else if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap--;
        end else if (pending_requests.size() != 0) begin
            req       <= pending_requests.pop_front();
            req_valid <= 1'b1;
            send_gap  = pause_len(send_burst);
        end else begin
            req_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted response word, then draw the next stall
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        rsp_t want;
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (expected_responses.size() == 0) begin
                    report("unexpected response", rsp.tour_cost, 0);
                end else begin
                    want = expected_responses.pop_front();
                    if (rsp.cost_delta !== want.cost_delta)
                        report("cost_delta", rsp.cost_delta, want.cost_delta);
                    if (rsp.tour_cost !== want.tour_cost)
                        report("tour_cost", rsp.tour_cost, want.tour_cost);
                    if (rsp.city_at_pos !== want.city_at_pos)
                        report("city_at_pos", rsp.city_at_pos, want.city_at_pos);
                    if (rsp.status !== want.status)
                        report("status", rsp.status, want.status);
                end
                hold_left = pause_len(take_burst);
            end else if (hold_left != 0) begin
                hold_left--;
            end
            rsp_stall <= (hold_left != 0);
        end
    end

    // Cycle count, burst stretches on both sides, and the hard limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles % 500 == 0) begin
            send_burst = ($urandom_range(0, 3) == 0);
            take_burst = ($urandom_range(0, 3) == 0);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        int counts [7];
        int budget [7];
        counts = '{8, 20, 4, 256, 13, 3, 100};
        budget = '{150, 200, 120, 40, 180, 100, 130};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest tour: bad cities and request codes, then every request kind.
        set_count(3);
        do_load(0, 1, 24'h123456);
        do_load(NCITY + 1, 5, '1);
        do_load(3, 511, 24'hABCDEF);
        send(make_req(3'd5));
        send(make_req(3'd6));
        send(make_req(3'd7));
        do_read(4);
        do_load(1, 2, '1);
        do_load(2, 3, '0);
        do_load(3, 1, 24'h800001);
        do_build();
        for (int p = 0; p <= 3; p++)
            do_read(p);
        do_move(REQ_EVAL, KIND_SWAP, 1, 2);
        do_move(REQ_APPLY, KIND_SWAP, 1, 2);
        do_move(REQ_APPLY, KIND_TWO_OPT, 0, 2);
        do_move(REQ_EVAL, KIND_TWO_OPT, 0, 3);
        do_move(REQ_EVAL, KIND_SWAP, 0, 1);
        do_move(REQ_EVAL, KIND_OR2, 1, 3);
        do_move(REQ_APPLY, KIND_OR3, 0, 2);
        do_move(REQ_EVAL, KIND_TWO_OPT, 2, 1);

        // Counts outside the legal range: everything but loads is refused.
        set_count(0);
        do_build();
        do_read(0);
        do_move(REQ_EVAL, KIND_SWAP, 1, 2);
        do_load(NCITY, NCITY, '1);
        set_count(2);
        do_build();
        do_move(REQ_APPLY, KIND_TWO_OPT, 0, 1);
        set_count(NCITY + 1);
        do_read(1);
        do_build();
        set_count(511);
        do_move(REQ_EVAL, KIND_OR2, 1, 4);
        do_read(256);

        // Random phases; later counts reuse the tour as it stands.
        for (int ph = 0; ph < 7; ph++) begin
            set_count(counts[ph]);
            if (counts[ph] == NCITY) begin
                do_build();
                do_read(NCITY);
                do_move(REQ_APPLY, KIND_TWO_OPT, 0, NCITY - 1);
                do_move(REQ_EVAL, KIND_SWAP, 1, NCITY - 1);
            end
            for (int it = 0; it < budget[ph]; it++)
                random_item();
        end

        drain();
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tspls_pkg.sv
sv/tsp_local_search_move_engine_core.sv
dv/tb_tsp_local_search_move_engine_core.sv
